// ===== design/xml_char_reference_decoder_core_macros.svh =====
// assertion helpers shared by the decoder modules
`ifndef XML_CHAR_REFERENCE_DECODER_CORE_MACROS_SVH
`define XML_CHAR_REFERENCE_DECODER_CORE_MACROS_SVH

// condition that must hold on every clock edge out of reset
`define XCR_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// consequence that must hold in the cycle after the antecedent
`define XCR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/xcr_pkg.sv =====
package xcr_pkg;

  // decode phase of the reference body
  typedef enum logic [2:0] {
    PH_START = 3'd0,
    PH_NAME  = 3'd1,
    PH_HASH  = 3'd2,
    PH_DEC   = 3'd3,
    PH_HEX   = 3'd4
  } phase_t;

  // byte class found by the front end
  typedef enum logic [2:0] {
    CL_DATA    = 3'd0,
    CL_SEMI    = 3'd1,
    CL_HASH    = 3'd2,
    CL_LOWER_X = 3'd3,
    CL_EOD     = 3'd4
  } class_t;

  // one classified transaction held in the queue
  typedef struct packed {
    class_t     cls;
    logic       dec_ok;
    logic       hex_ok;
    logic [3:0] nibble;
    logic [7:0] ch;
  } entry_t;

  localparam int CODE_W      = 32;
  localparam int NAME_DEPTH  = 4;
  localparam int NAME_IDX_W  = 2;

  localparam logic [2:0] NAME_TOO_LONG = 3'd5;

  localparam logic [7:0] CH_SEMI    = 8'h3B;
  localparam logic [7:0] CH_HASH    = 8'h23;
  localparam logic [7:0] CH_LOWER_X = 8'h78;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_F = 8'h66;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_F = 8'h46;
  localparam logic [7:0] HEX_LOWER_BIAS = 8'd87;
  localparam logic [7:0] HEX_UPPER_BIAS = 8'd55;

  // known entity names, first character in the top byte
  localparam logic [15:0] NAME_GT   = "gt";
  localparam logic [15:0] NAME_LT   = "lt";
  localparam logic [23:0] NAME_AMP  = "amp";
  localparam logic [31:0] NAME_APOS = "apos";
  localparam logic [31:0] NAME_QUOT = "quot";

  localparam logic [CODE_W-1:0] CODE_GT   = 32'h3E;
  localparam logic [CODE_W-1:0] CODE_LT   = 32'h3C;
  localparam logic [CODE_W-1:0] CODE_AMP  = 32'h26;
  localparam logic [CODE_W-1:0] CODE_APOS = 32'h27;
  localparam logic [CODE_W-1:0] CODE_QUOT = 32'h22;

endpackage

// ===== design/xcr_front.sv =====
module xcr_front (
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [7:0]        s_tdata,   // [7:0] data_byte
  input  logic              s_tuser,   // [0] func
  output logic              push_valid,
  input  logic              push_ready,
  output xcr_pkg::entry_t   push_data
);
  import xcr_pkg::*;

  logic       is_dec;
  logic       is_lower;
  logic       is_upper;
  logic [7:0] dec_val;
  logic [7:0] lower_val;
  logic [7:0] upper_val;

  // digit detection and digit values
  always_comb begin
    is_dec    = (s_tdata >= CH_ZERO) && (s_tdata <= CH_NINE);
    is_lower  = (s_tdata >= CH_LOWER_A) && (s_tdata <= CH_LOWER_F);
    is_upper  = (s_tdata >= CH_UPPER_A) && (s_tdata <= CH_UPPER_F);
    dec_val   = s_tdata - CH_ZERO;
    lower_val = s_tdata - HEX_LOWER_BIAS;
    upper_val = s_tdata - HEX_UPPER_BIAS;
  end

  // byte class and queue entry
  always_comb begin
    push_data.ch     = s_tdata;
    push_data.dec_ok = is_dec;
    push_data.hex_ok = is_dec || is_lower || is_upper;
    if (is_dec) begin
      push_data.nibble = dec_val[3:0];
    end else if (is_lower) begin
      push_data.nibble = lower_val[3:0];
    end else if (is_upper) begin
      push_data.nibble = upper_val[3:0];
    end else begin
      push_data.nibble = 4'd0;
    end
    if (s_tuser) begin
      push_data.cls = CL_EOD;
    end else if (s_tdata == CH_SEMI) begin
      push_data.cls = CL_SEMI;
    end else if (s_tdata == CH_HASH) begin
      push_data.cls = CL_HASH;
    end else if (s_tdata == CH_LOWER_X) begin
      push_data.cls = CL_LOWER_X;
    end else begin
      push_data.cls = CL_DATA;
    end
  end

  // handshake toward the queue
  assign push_valid = s_tvalid;
  assign s_tready   = push_ready;

endmodule

// ===== design/xcr_queue.sv =====
module xcr_queue #(
  parameter int DEPTH = 2
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  xcr_pkg::entry_t in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output xcr_pkg::entry_t out_data
);
  import xcr_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL = CW'(DEPTH);

  entry_t        slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          push;
  logic          pop;

  assign in_ready  = (count != FULL);
  assign out_valid = (count != '0);
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign out_data  = slots[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_data;
    end
  end

`include "xml_char_reference_decoder_core_macros.svh"

  `XCR_ASSERT_ALWAYS(a_count_bound, count <= FULL, "queue count exceeds depth")
  `XCR_ASSERT_NEXT(a_count_up, push && !pop, count == $past(count) + 1'b1, "queue count missed a push")

endmodule

// ===== design/xcr_back.sv =====
module xcr_back (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  xcr_pkg::entry_t            in_data,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [xcr_pkg::CODE_W-1:0] m_tdata,   // [31:0] code_point
  output logic                       m_tuser    // [0] by_semicolon
);
  import xcr_pkg::*;

  phase_t              phase;
  phase_t              phase_next;
  logic [CODE_W-1:0]   acc;
  logic [CODE_W-1:0]   acc_next;
  logic [2:0]          name_len;
  logic [2:0]          name_len_next;
  logic [7:0]          name_chars [NAME_DEPTH];
  logic                name_wr;
  logic                emits;
  logic                take;
  logic                res_semi;
  logic [CODE_W-1:0]   res_code;
  logic [CODE_W-1:0]   named;
  logic [CODE_W-1:0]   acc_dec;
  logic [CODE_W-1:0]   acc_hex;
  logic                out_valid_next;

  // only a closing transaction needs the output slot
  assign emits    = (in_data.cls == CL_EOD) || (in_data.cls == CL_SEMI);
  assign in_ready = !emits || !m_tvalid || m_tready;
  assign take     = in_valid && in_ready;

  // digit accumulation, times ten as two shifts
  assign acc_dec = (acc << 3) + (acc << 1) + CODE_W'(in_data.nibble);
  assign acc_hex = (acc << 4) + CODE_W'(in_data.nibble);

  // entity name lookup
  always_comb begin
    named = '0;
    if (name_len == 3'd2 && {name_chars[0], name_chars[1]} == NAME_GT) begin
      named = CODE_GT;
    end else if (name_len == 3'd2 && {name_chars[0], name_chars[1]} == NAME_LT) begin
      named = CODE_LT;
    end else if (name_len == 3'd3 &&
                 {name_chars[0], name_chars[1], name_chars[2]} == NAME_AMP) begin
      named = CODE_AMP;
    end else if (name_len == 3'd4 && {name_chars[0], name_chars[1], name_chars[2],
                                      name_chars[3]} == NAME_APOS) begin
      named = CODE_APOS;
    end else if (name_len == 3'd4 && {name_chars[0], name_chars[1], name_chars[2],
                                      name_chars[3]} == NAME_QUOT) begin
      named = CODE_QUOT;
    end
  end

  // phase transitions and result selection
  always_comb begin
    phase_next    = phase;
    acc_next      = acc;
    name_len_next = name_len;
    name_wr       = 1'b0;
    res_semi      = (in_data.cls == CL_SEMI);
    res_code      = '0;
    case (phase)
      PH_START: begin
        if (in_data.cls == CL_HASH) begin
          phase_next = PH_HASH;
        end else if (!emits) begin
          phase_next    = PH_NAME;
          name_wr       = 1'b1;
          name_len_next = 3'd1;
        end
      end
      PH_NAME: begin
        if (in_data.cls == CL_SEMI) begin
          res_code = named;
        end else if (!emits) begin
          if (name_len < 3'(NAME_DEPTH)) begin
            name_wr       = 1'b1;
            name_len_next = name_len + 1'b1;
          end else begin
            name_len_next = NAME_TOO_LONG;
          end
        end
      end
      PH_HASH: begin
        res_code = acc;
        if (in_data.cls == CL_LOWER_X) begin
          phase_next = PH_HEX;
        end else if (!emits) begin
          phase_next = PH_DEC;
          if (in_data.dec_ok) begin
            acc_next = acc_dec;
          end
        end
      end
      PH_DEC: begin
        res_code = acc;
        if (!emits && in_data.dec_ok) begin
          acc_next = acc_dec;
        end
      end
      PH_HEX: begin
        res_code = acc;
        if (!emits && in_data.hex_ok) begin
          acc_next = acc_hex;
        end
      end
      default: begin
        phase_next = PH_START;
      end
    endcase
    // a closed reference returns to the start phase
    if (emits) begin
      phase_next    = PH_START;
      acc_next      = '0;
      name_len_next = 3'd0;
      name_wr       = 1'b0;
    end
  end

  assign out_valid_next = (take && emits) ? 1'b1 : (m_tready ? 1'b0 : m_tvalid);

  // state and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_START;
      acc      <= '0;
      name_len <= 3'd0;
      m_tvalid <= 1'b0;
    end else begin
      if (take) begin
        phase    <= phase_next;
        acc      <= acc_next;
        name_len <= name_len_next;
      end
      m_tvalid <= out_valid_next;
    end
  end

  // name bytes and result payload
  always_ff @(posedge clk) begin
    if (take && name_wr) begin
      name_chars[name_len[NAME_IDX_W-1:0]] <= in_data.ch;
    end
    if (take && emits) begin
      m_tdata <= res_code;
      m_tuser <= res_semi;
    end
  end

`include "xml_char_reference_decoder_core_macros.svh"

  `XCR_ASSERT_ALWAYS(a_name_len_range, name_len <= NAME_TOO_LONG, "name length out of range")
  `XCR_ASSERT_NEXT(a_close_resets, take && emits, phase == PH_START && acc == '0 && m_tvalid, "close did not reset state or raise a result")

endmodule

// ===== design/xml_char_reference_decoder_core.sv =====
// Decodes the body of an XML character reference (the bytes after '&'),
// one byte per transaction on the slave side, and gives one result per
// ';' byte or end-of-data marker (s_tuser high) on the master side. The
// block takes one byte every cycle while the queue has room: the back end
// updates its phase and accumulator as each byte is taken (times ten is a
// shift-and-add), and a closing byte only waits when the output register is
// full and not being taken. A result passes through the classified byte
// queue and then the output register after its closing byte is accepted.
// Decimal and hex codes wrap modulo 2^32; an unknown or over-long name
// gives code 0.
module xml_char_reference_decoder_core #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tuser,   // [0] func
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] code_point
  output logic        m_tuser    // [0] by_semicolon
);
  import xcr_pkg::*;

  logic   push_valid;
  logic   push_ready;
  entry_t push_data;
  logic   pop_valid;
  logic   pop_ready;
  entry_t pop_data;

  // byte classification
  xcr_front u_front (
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  // decoupling queue
  xcr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (push_valid),
    .in_ready  (push_ready),
    .in_data   (push_data),
    .out_valid (pop_valid),
    .out_ready (pop_ready),
    .out_data  (pop_data)
  );

  // phase machine, accumulator and result register
  xcr_back u_back (
    .clk      (clk),
    .rst      (rst),
    .in_valid (pop_valid),
    .in_ready (pop_ready),
    .in_data  (pop_data),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

// ===== test/xml_char_reference_decoder_core_checker.sv =====
`default_nettype none

module xml_char_reference_decoder_core_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  input  wire logic        s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
  input  wire logic        s_tuser,   // [0] func
  input  wire logic        m_tvalid,
  input  wire logic        m_tready,
  input  wire logic [31:0] m_tdata,   // [31:0] code_point
  input  wire logic        m_tuser,   // [0] by_semicolon
  output int               fail_count,
  output int               outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import xcr_pkg::*;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic              semi;
  } decoded_t;

  // expected results, oldest first
  decoded_t decoded_q[$];
  int errors = 0;

  // mirrored decoder state
  phase_t            ph;
  logic [CODE_W-1:0] acc;
  logic [7:0]        name_buf [NAME_DEPTH];
  logic [2:0]        name_len;

  assign fail_count = errors;

  // code of a recognized entity name, zero otherwise
  function automatic logic [CODE_W-1:0] lookup_name();
    if (name_len == 3'd2 && {name_buf[0], name_buf[1]} == NAME_GT) return CODE_GT;
    if (name_len == 3'd2 && {name_buf[0], name_buf[1]} == NAME_LT) return CODE_LT;
    if (name_len == 3'd3 && {name_buf[0], name_buf[1], name_buf[2]} == NAME_AMP)
      return CODE_AMP;
    if (name_len == 3'd4 &&
        {name_buf[0], name_buf[1], name_buf[2], name_buf[3]} == NAME_APOS)
      return CODE_APOS;
    if (name_len == 3'd4 &&
        {name_buf[0], name_buf[1], name_buf[2], name_buf[3]} == NAME_QUOT)
      return CODE_QUOT;
    return '0;
  endfunction

  // queue one decoded result and go back to the start phase
  task automatic close_reference(input logic [CODE_W-1:0] code, input logic semi);
    decoded_q.push_back('{code, semi});
    ph = PH_START;
    acc = '0;
    name_len = '0;
  endtask

  // apply one accepted byte or end-of-data marker to the mirrored state
  task automatic advance_reference(input logic eod, input logic [7:0] ch);
    logic taken;
    taken = 1'b0;
    if (eod) begin
      if (ph == PH_DEC || ph == PH_HEX || ph == PH_HASH)
        close_reference(acc, 1'b0);
      else
        close_reference('0, 1'b0);
      taken = 1'b1;
    end else begin
      case (ph)
        PH_START: begin
          if (ch == CH_HASH) begin
            ph = PH_HASH;
            taken = 1'b1;
          end else begin
            ph = PH_NAME;
          end
        end
        PH_HASH: begin
          if (ch == CH_LOWER_X) begin
            ph = PH_HEX;
            taken = 1'b1;
          end else begin
            ph = PH_DEC;
          end
        end
        PH_NAME, PH_DEC, PH_HEX: ;
        default: begin
          ph = PH_START;
          taken = 1'b1;
        end
      endcase
    end
    if (!taken) begin
      if (ch == CH_SEMI) begin
        if (ph == PH_NAME)
          close_reference(lookup_name(), 1'b1);
        else
          close_reference(acc, 1'b1);
      end else begin
        case (ph)
          PH_NAME: begin
            if (name_len < NAME_DEPTH) begin
              name_buf[name_len[NAME_IDX_W-1:0]] = ch;
              name_len = name_len + 3'd1;
            end else begin
              name_len = NAME_TOO_LONG;
            end
          end
          PH_DEC: begin
            if (ch >= CH_ZERO && ch <= CH_NINE)
              acc = acc * 10 + (ch - CH_ZERO);
          end
          default: begin
            // hex digit, either case
            if (ch >= CH_ZERO && ch <= CH_NINE)
              acc = (acc << 4) + (ch - CH_ZERO);
            else if (ch >= CH_LOWER_A && ch <= CH_LOWER_F)
              acc = (acc << 4) + ch - HEX_LOWER_BIAS;
            else if (ch >= CH_UPPER_A && ch <= CH_UPPER_F)
              acc = (acc << 4) + ch - HEX_UPPER_BIAS;
          end
        endcase
      end
    end
  endtask

  // compare results first, then predict from the input transaction
  always @(posedge clk) begin
    decoded_t want;
    if (rst) begin
      ph = PH_START;
      acc = '0;
      name_len = '0;
      foreach (name_buf[i]) name_buf[i] = '0;
      decoded_q.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        if (decoded_q.size() == 0) begin
          $display("%0t unexpected result: code_point %h by_semicolon %b",
                   $time, m_tdata, m_tuser);
          errors = errors + 1;
        end else begin
          want = decoded_q.pop_front();
          if (m_tdata !== want.code) begin
            $display("%0t code_point mismatch: expected %h, actual %h",
                     $time, want.code, m_tdata);
            errors = errors + 1;
          end
          if (m_tuser !== want.semi) begin
            $display("%0t by_semicolon mismatch: expected %b, actual %b",
                     $time, want.semi, m_tuser);
            errors = errors + 1;
          end
        end
      end
      if (s_tvalid && s_tready)
        advance_reference(s_tuser, s_tdata);
    end
    outstanding <= decoded_q.size();
  end

endmodule

`default_nettype wire

// ===== test/xml_char_reference_decoder_core_tb.sv =====
`default_nettype none

module xml_char_reference_decoder_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import xcr_pkg::*;

  localparam int RANDOM_ITEMS = 750;
  localparam int STALL_LIMIT  = 1000;
  localparam int HOLD_CYCLES  = 150;

  typedef struct packed {
    logic       eod;
    logic [7:0] ch;
  } ref_byte_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;   // [7:0] data_byte
  logic        s_tuser;   // [0] func
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;   // [31:0] code_point
  logic        m_tuser;   // [0] by_semicolon
  int          fail_count;
  int          outstanding;
  int          idle_cycles = 0;

  ref_byte_t stim_q[$];
  string     known_names[5] = '{"gt", "lt", "amp", "apos", "quot"};
  string     hex_digits = "0123456789abcdefABCDEF";

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  xml_char_reference_decoder_core u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  xml_char_reference_decoder_core_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  task automatic add_byte(input logic [7:0] b);
    stim_q.push_back('{1'b0, b});
  endtask

  // end-of-data marker with junk in the ignored byte
  task automatic add_eod();
    logic [7:0] junk;
    junk = 8'($urandom_range(0, 255));
    stim_q.push_back('{1'b1, junk});
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endtask

  task automatic add_close();
    if ($urandom_range(0, 3) == 0) add_eod();
    else add_byte(CH_SEMI);
  endtask

  // random byte that cannot close a reference
  function automatic logic [7:0] open_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    if (b == CH_SEMI) b = 8'h67;
    return b;
  endfunction

  // one random reference, mostly well formed
  task automatic add_random_reference();
    int    kind;
    int    n;
    string s;
    logic [7:0] b;
    kind = $urandom_range(0, 9);
    case (kind)
      0, 1, 2: begin
        s = known_names[$urandom_range(0, 4)];
        if ($urandom_range(0, 3) == 0) begin
          b = open_byte();
          if (b == CH_HASH) b = 8'h71;
          s.putc($urandom_range(0, s.len() - 1), b);
        end else if ($urandom_range(0, 5) == 0) begin
          s = s.substr(0, s.len() - 2);
        end else if ($urandom_range(0, 5) == 0) begin
          s = {s, "s"};
        end
        add_text(s);
        add_close();
      end
      3: begin
        n = $urandom_range(1, 7);
        for (int i = 0; i < n; i++) begin
          b = open_byte();
          if (i == 0 && b == CH_HASH) b = 8'h61;
          add_byte(b);
        end
        add_close();
      end
      4, 5: begin
        add_byte(CH_HASH);
        if ($urandom_range(0, 5) == 0) add_byte(8'h58);
        n = $urandom_range(0, 12);
        for (int i = 0; i < n; i++) begin
          if ($urandom_range(0, 5) == 0) add_byte(open_byte());
          else add_byte(CH_ZERO + 8'($urandom_range(0, 9)));
        end
        add_close();
      end
      6, 7: begin
        add_byte(CH_HASH);
        add_byte(CH_LOWER_X);
        n = $urandom_range(0, 10);
        for (int i = 0; i < n; i++) begin
          if ($urandom_range(0, 5) == 0) add_byte(open_byte());
          else add_byte(hex_digits[$urandom_range(0, hex_digits.len() - 1)]);
        end
        add_close();
      end
      8: begin
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++) begin
          if ($urandom_range(0, 4) == 0) add_eod();
          else add_byte(8'($urandom_range(0, 255)));
        end
      end
      default: begin
        add_byte(CH_HASH);
        add_close();
      end
    endcase
  endtask

  // stall watchdog: no transaction on either side for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("xml_char_reference_decoder_core verification failed");
        $finish;
      end
    end
  end

  // result side: random back-pressure with two long hold-offs
  initial begin
    int   taken;
    int   gap;
    logic rx_burst;
    taken = 0;
    rx_burst = 1'b0;
    m_tready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (taken % 32 == 0) rx_burst = ($urandom_range(0, 3) == 0);
      if (taken == 15 || taken == 70) gap = HOLD_CYCLES;
      else if (rx_burst) gap = 0;
      else gap = $urandom_range(0, 19);
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      taken = taken + 1;
      @(negedge clk);
    end
  end

  // byte side: directed references, then random ones
  initial begin
    int   directed_count;
    int   gap;
    logic tx_burst;
    logic pause;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = 1'b0;
    tx_burst = 1'b0;

    // empty name, known name, semicolon after hash, upper-case X, mixed-case hex
    add_byte(CH_SEMI);
    add_text("gt;");
    add_text("#;");
    add_text("#X7A;");
    add_text("#xfF0;");
    // end of data in hex, name, after-hash and start phases
    add_text("#x9");
    add_eod();
    add_byte(8'h00);
    add_byte(8'hFF);
    add_eod();
    add_text("#");
    add_eod();
    add_eod();
    directed_count = stim_q.size();
    while (stim_q.size() < directed_count + RANDOM_ITEMS) add_random_reference();

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (stim_q[i]) begin
      if (i % 40 == 0) tx_burst = ($urandom_range(0, 3) == 0);
      pause = (i == directed_count || i == directed_count + 400);
      gap = tx_burst ? 0 : $urandom_range(0, 19);
      if (gap > 0 || pause) begin
        s_tvalid <= 1'b0;
        if (pause) begin
          wait (outstanding == 0);
          @(negedge clk);
        end
        repeat (gap) @(negedge clk);
      end
      s_tvalid <= 1'b1;
      s_tuser <= stim_q[i].eod;
      s_tdata <= stim_q[i].ch;
      do @(posedge clk); while (!s_tready);
      @(negedge clk);
    end
    s_tvalid <= 1'b0;

    wait (outstanding == 0);
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("xml_char_reference_decoder_core verification clean");
    end else begin
      $display("xml_char_reference_decoder_core verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
+incdir+design
design/xcr_pkg.sv
design/xcr_front.sv
design/xcr_queue.sv
design/xcr_back.sv
design/xml_char_reference_decoder_core.sv
test/xml_char_reference_decoder_core_checker.sv
test/xml_char_reference_decoder_core_tb.sv
